// ===== rtl/wdt_pkg.sv =====
// Package for the watchdog timer peripheral: request and result types,
// register offsets, control and status bit positions, widths.
// No dependencies.
package wdt_pkg;

    localparam int COUNT_WIDTH    = 8;
    localparam int PRESCALE_WIDTH = 16;
    localparam int LIMIT_WIDTH    = ((PRESCALE_WIDTH > 16) ? PRESCALE_WIDTH : 16) + 1;

    localparam logic [15:0] TPH_RESET    = 16'd16384;
    localparam logic [15:0] CTL_RESET    = 16'h0030;
    localparam logic [15:0] SERVICE_KEY1 = 16'h5555;
    localparam logic [15:0] SERVICE_KEY2 = 16'haaaa;

    localparam int CTL_SUSPEND  = 0;
    localparam int CTL_ENABLE   = 2;
    localparam int CTL_EXTSEL   = 3;
    localparam int CTL_SWRST_N  = 4;
    localparam int CTL_EXTRST_N = 5;
    localparam int CTL_WT_LSB   = 8;

    localparam int ST_SOFT = 0;
    localparam int ST_WDOG = 1;
    localparam int ST_COLD = 4;
    localparam logic [4:0] STATUS_RESET = 5'h10;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        OFF_CONTROL = 4'h0,
        OFF_SERVICE = 4'h2,
        OFF_STATUS  = 4'h4,
        OFF_MISC    = 4'h8
    } t_offset;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  reg_offset;
        logic [15:0] write_data;
        logic        low_power;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic        internal_reset;
        logic        external_reset;
        logic        timed_out;
    } t_out_item;

endpackage

// ===== rtl/wdt_core.sv =====
// Watchdog register file, prescaler, timeout counter and service sequence.
// Updates state on each accepted request and returns its result combinationally.
// Depends on wdt_pkg.
module wdt_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_fire,
    input  wdt_pkg::t_in_item  i_item,
    output wdt_pkg::t_out_item o_result
);
    import wdt_pkg::*;

    logic [15:0]               r_tph;
    logic [15:0]               r_ctl,    n_ctl;
    logic [COUNT_WIDTH-1:0]    r_hs,     n_hs;
    logic [PRESCALE_WIDTH-1:0] r_pre,    n_pre;
    logic                      r_armed,  n_armed;
    logic [4:0]                r_status, n_status;
    logic                      r_pde,    n_pde;

    logic [LIMIT_WIDTH-1:0]    w_pre_inc;
    logic [LIMIT_WIDTH-1:0]    w_limit;
    logic                      w_step;
    logic                      w_run;
    logic [COUNT_WIDTH-1:0]    w_wt;
    t_op                       w_op;
    t_out_item                 w_res;

    assign w_op      = t_op'(i_item.operation);
    assign w_pre_inc = LIMIT_WIDTH'(r_pre) + LIMIT_WIDTH'(1);
    assign w_limit   = (r_tph == 16'd0) ? LIMIT_WIDTH'(1) : LIMIT_WIDTH'(r_tph);
    assign w_step    = (w_pre_inc >= w_limit) || (r_pre == '1);
    assign w_run     = r_ctl[CTL_ENABLE] && !(i_item.low_power && r_ctl[CTL_SUSPEND]);
    assign w_wt      = r_ctl[CTL_WT_LSB +: COUNT_WIDTH];

    always_comb begin
        n_ctl    = r_ctl;
        n_hs     = r_hs;
        n_pre    = r_pre;
        n_armed  = r_armed;
        n_status = r_status;
        n_pde    = r_pde;
        w_res    = '0;
        case (w_op)
            OP_TICK: begin
                if (w_run) begin
                    if (w_step) begin
                        n_pre = '0;
                        if (r_hs >= w_wt) begin
                            n_hs = '0;
                            w_res.timed_out = 1'b1;
                            n_status[ST_WDOG] = 1'b1;
                            if (r_ctl[CTL_EXTSEL]) begin
                                n_ctl[CTL_EXTRST_N] = 1'b0;
                            end else begin
                                w_res.internal_reset = 1'b1;
                            end
                        end else begin
                            n_hs = r_hs + COUNT_WIDTH'(1);
                        end
                    end else begin
                        n_pre = r_pre + PRESCALE_WIDTH'(1);
                    end
                end
            end
            OP_WRITE: begin
                case (i_item.reg_offset)
                    OFF_CONTROL: begin
                        if (!i_item.write_data[CTL_SWRST_N]) begin
                            w_res.internal_reset = 1'b1;
                            n_status[ST_SOFT] = 1'b1;
                        end
                        n_ctl = i_item.write_data;
                        n_ctl[CTL_SWRST_N] = 1'b1;
                        n_ctl[CTL_ENABLE]  = i_item.write_data[CTL_ENABLE]
                                             | r_ctl[CTL_ENABLE];
                        n_ctl[CTL_SUSPEND] = i_item.write_data[CTL_SUSPEND]
                                             | r_ctl[CTL_SUSPEND];
                    end
                    OFF_SERVICE: begin
                        if (i_item.write_data == SERVICE_KEY1) begin
                            n_armed = 1'b1;
                        end else begin
                            if (i_item.write_data == SERVICE_KEY2 && r_armed) begin
                                n_hs  = '0;
                                n_pre = '0;
                            end
                            n_armed = 1'b0;
                        end
                    end
                    OFF_MISC: begin
                        n_pde = r_pde & i_item.write_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            OP_READ: begin
                case (i_item.reg_offset)
                    OFF_CONTROL: w_res.read_data = r_ctl;
                    OFF_STATUS:  w_res.read_data = {11'd0, r_status[ST_COLD], 2'b00,
                                                    r_status[ST_WDOG], r_status[ST_SOFT]};
                    OFF_MISC:    w_res.read_data = {15'd0, r_pde};
                    default:     w_res.read_data = '0;
                endcase
            end
            default: begin
            end
        endcase
        w_res.external_reset = !n_ctl[CTL_EXTRST_N];
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tph <= TPH_RESET;
        end else if (i_cfg_we) begin
            r_tph <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl    <= CTL_RESET;
            r_hs     <= '0;
            r_pre    <= '0;
            r_armed  <= 1'b0;
            r_status <= STATUS_RESET;
            r_pde    <= 1'b1;
        end else if (i_fire) begin
            r_ctl    <= n_ctl;
            r_hs     <= n_hs;
            r_pre    <= n_pre;
            r_armed  <= n_armed;
            r_status <= n_status;
            r_pde    <= n_pde;
        end
    end

endmodule

// ===== rtl/watchdog_timer_peripheral_core.sv =====
// Watchdog timer peripheral top level: request channel, result register with
// skid stage, configuration port. Depends on wdt_pkg and wdt_core.
// Results are registered; the skid stage holds a result while the output stalls.
// One request per cycle is accepted until the skid stage fills and stalls input.
// Synchronous active-low reset restores register reset values and empties the
// result buffers; ticks_per_half_second resets to 16384.
module watchdog_timer_peripheral_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wdt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wdt_pkg::t_out_item o_out_item
);
    import wdt_pkg::*;

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_item r_out;
    t_out_item r_skid;
    t_out_item w_result;
    logic      w_fire;
    logic      w_out_free;

    assign w_fire     = i_in_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;

    wdt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_fire),
        .i_item      (i_in_item),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid  <= r_skid_valid || w_fire;
                r_skid_valid <= 1'b0;
            end else if (w_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end
        if (w_fire && !w_out_free) begin
            r_skid <= w_result;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid filled while output was free");

    a_timeout_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.timed_out) |->
            (o_out_item.read_data == 16'd0 &&
             (o_out_item.internal_reset || o_out_item.external_reset)))
        else $error("timeout result without reset action");

endmodule
